### hw/rtl/skf_pkg.sv
`timescale 1ns / 1ps
// Shared constants and codes for the scalar Kalman filter core.
// No dependencies.
package skf_pkg;

	localparam int DATA_W    = 32;                   // estimate / variance width
	localparam int FRAC_BITS = 16;                   // fraction bits of Q16.16 values
	localparam int GAIN_BITS = 16;                   // gain is Q0.16
	localparam int GAIN_W    = GAIN_BITS + 1;        // 0 .. 1.0 inclusive
	localparam int CNT_W     = $clog2(GAIN_W + 1);   // serial step counter
	localparam int MC_W      = DATA_W + 2;           // multiplicand: 33-bit diff, sign ext
	localparam int ACC_W     = MC_W + 2;             // multiplier accumulator
	localparam int CFG_IDX_W = 3;

	localparam logic [DATA_W-1:0] FIX_ONE  = DATA_W'(1) << FRAC_BITS;
	localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << GAIN_BITS;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MEASUREMENT_NOISE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INITIAL_ESTIMATE  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INITIAL_VARIANCE  = 3'd3;

	// operation codes
	localparam logic OP_FILTER  = 1'b0;
	localparam logic OP_RESTART = 1'b1;

endpackage

### hw/rtl/skf_in_if.sv
`timescale 1ns / 1ps
// Input channel: operation and measurement with valid/ready.
// Depends on skf_pkg.
interface skf_in_if;
	import skf_pkg::*;

	logic                     valid;
	logic                     ready;
	logic                     operation;
	logic signed [DATA_W-1:0] measurement;

	modport source (output valid, operation, measurement, input ready);
	modport sink   (input valid, operation, measurement, output ready);
endinterface

### hw/rtl/skf_out_if.sv
`timescale 1ns / 1ps
// Result channel: filtered value, gain and variance with valid/ready.
// Depends on skf_pkg.
interface skf_out_if;
	import skf_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] filtered_value;
	logic        [GAIN_W-1:0] kalman_gain;
	logic        [DATA_W-1:0] error_variance;

	modport source (output valid, filtered_value, kalman_gain, error_variance, input ready);
	modport sink   (input valid, filtered_value, kalman_gain, error_variance, output ready);
endinterface

### hw/rtl/skf_div.sv
`timescale 1ns / 1ps
// Radix-2 restoring divider: gain = floor(num * 2^16 / den), one quotient bit per cycle.
// Depends on skf_pkg. Requires num <= den.
module skf_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [skf_pkg::DATA_W-1:0]   num,
	input  logic [skf_pkg::DATA_W:0]     den,
	output logic                         done,
	output logic [skf_pkg::GAIN_W-1:0]   quo
);
	import skf_pkg::*;

	logic [DATA_W+1:0] rem_q;
	logic [DATA_W:0]   den_q;
	logic [GAIN_W-1:0] quo_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic              ge;
	logic [DATA_W+1:0] rem_next;

	assign ge       = rem_q >= {1'b0, den_q};
	assign rem_next = ge ? (rem_q - {1'b0, den_q}) : rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(GAIN_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {2'b00, num};
			den_q <= den;
			quo_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[GAIN_W-2:0], ge};
			rem_q <= {rem_next[DATA_W:0], 1'b0};
		end
	end

	// zero denominator means p and r are both zero: gain is zero
	assign quo  = (den_q == '0) ? '0 : quo_q;
	assign done = done_q;

	a_rem_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && (den_q != '0) |-> rem_q < {den_q, 1'b0})
		else $error("divider remainder out of range");

endmodule

### hw/rtl/skf_mul.sv
`timescale 1ns / 1ps
// Shift-add multiplier, one multiplier bit per cycle, LSB first.
// Depends on skf_pkg. prod = floor(mcand * mplier / 2^16).
module skf_mul (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic signed [skf_pkg::MC_W-1:0]    mcand,
	input  logic        [skf_pkg::GAIN_W-1:0]  mplier,
	output logic                               done,
	output logic signed [skf_pkg::ACC_W-1:0]   prod
);
	import skf_pkg::*;

	logic signed [MC_W-1:0]  a_q;
	logic        [GAIN_W-1:0] b_q;
	logic signed [ACC_W-1:0] acc_q;
	logic [CNT_W-1:0]        cnt_q;
	logic                    busy_q;
	logic                    done_q;
	logic signed [ACC_W-1:0] addend;
	logic signed [ACC_W-1:0] sum;
	logic                    last;

	assign addend = b_q[0] ? {{(ACC_W-MC_W){a_q[MC_W-1]}}, a_q} : '0;
	assign sum    = acc_q + addend;
	assign last   = cnt_q == CNT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(GAIN_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (last) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// arithmetic shift each step floors; top bit weight 2^16 is added unshifted
	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= mcand;
			b_q   <= mplier;
			acc_q <= '0;
		end else if (busy_q) begin
			b_q   <= b_q >> 1;
			acc_q <= last ? sum : (sum >>> 1);
		end
	end

	assign prod = acc_q;
	assign done = done_q;

endmodule

### hw/rtl/scalar_kalman_filter_core.sv
`timescale 1ns / 1ps
// Scalar Kalman filter core, top level.
// Depends on skf_pkg, skf_in_if, skf_out_if, skf_div, skf_mul.
//
// Usage:
//   in_ch  (sink)  : one transaction per item, operation + measurement.
//                    operation OP_FILTER runs one filter step,
//                    OP_RESTART reloads estimate and variance from the
//                    initial_estimate / initial_variance registers.
//   out_ch (source): one transaction per item with the new estimate, the gain
//                    used (zero on restart) and the new variance.
//   cfg_*          : write-only register port; write only while idle (not enforced).
// Sequence: a filter item goes from input transaction to result valid through
//   prediction add, divider set-up, the radix-2 divider steps (one gain bit each),
//   a hand-off, the two shift-add multipliers (in parallel), a result latch and
//   the output register load. A restart goes straight to the output register load.
//   The next transaction can be accepted in the cycle after a result is loaded.
//   One item is processed at a time; in_ch.ready is high while idle, also
//   while a previous result still waits in the output register.
// Reset: registers return to their reset values (r = 1.0, initial variance 1.0,
//   q = 0, initial estimate 0); estimate = 0, variance = 1.0, nothing pending.
// Stall: a finished item waits in its final state until the output register
//   is free; the state update is committed when the result is loaded.
module scalar_kalman_filter_core (
	input  logic                             clk,
	input  logic                             arst_n,
	skf_in_if.sink                           in_ch,
	skf_out_if.source                        out_ch,
	input  logic                             cfg_we,
	input  logic [skf_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [skf_pkg::DATA_W-1:0]       cfg_data
);
	import skf_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_PRED  = 3'd1;
	localparam logic [2:0] ST_START = 3'd2;
	localparam logic [2:0] ST_DIV   = 3'd3;
	localparam logic [2:0] ST_MUL   = 3'd4;
	localparam logic [2:0] ST_DONE  = 3'd5;

	// configuration registers
	logic [DATA_W-1:0]        q_noise_q;
	logic [DATA_W-1:0]        r_noise_q;
	logic signed [DATA_W-1:0] init_est_q;
	logic [DATA_W-1:0]        init_var_q;

	// filter state
	logic signed [DATA_W-1:0] est_q;
	logic [DATA_W-1:0]        var_q;

	// per-item working registers
	logic [2:0]               state_q;
	logic signed [DATA_W-1:0] meas_q;
	logic [DATA_W-1:0]        p_q;
	logic signed [DATA_W:0]   diff_q;
	logic [GAIN_W-1:0]        gain_q;
	logic signed [DATA_W-1:0] res_est_q;
	logic [DATA_W-1:0]        res_var_q;

	// output register
	logic                     out_valid_q;
	logic signed [DATA_W-1:0] out_est_q;
	logic [GAIN_W-1:0]        out_gain_q;
	logic [DATA_W-1:0]        out_var_q;

	logic                     in_fire;
	logic                     out_load;
	logic [DATA_W:0]          p_sum;
	logic signed [DATA_W:0]   diff_w;
	logic [DATA_W:0]          den_w;
	logic                     div_start;
	logic                     div_done;
	logic [GAIN_W-1:0]        div_quo;
	logic                     mul_start;
	logic                     mul_e_done;
	logic                     mul_v_done;
	logic signed [ACC_W-1:0]  prod_e;
	logic signed [ACC_W-1:0]  prod_v;
	logic signed [ACC_W-1:0]  est_sum;
	logic signed [DATA_W-1:0] est_clamped;
	logic [GAIN_W-1:0]        one_minus_g;

	assign in_ch.ready = (state_q == ST_IDLE);
	assign in_fire     = in_ch.valid && in_ch.ready;
	assign out_load    = (state_q == ST_DONE) && (!out_valid_q || out_ch.ready);

	// config writes; unknown indexes fall through
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_noise_q  <= '0;
			r_noise_q  <= FIX_ONE;
			init_est_q <= '0;
			init_var_q <= FIX_ONE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PROCESS_NOISE:     q_noise_q  <= cfg_data;
				REG_MEASUREMENT_NOISE: r_noise_q  <= cfg_data;
				REG_INITIAL_ESTIMATE:  init_est_q <= cfg_data;
				REG_INITIAL_VARIANCE:  init_var_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// predict: p = sat(var + q); diff formed exactly at 33 bits
	assign p_sum  = {1'b0, var_q} + {1'b0, q_noise_q};
	assign diff_w = {meas_q[DATA_W-1], meas_q} - {est_q[DATA_W-1], est_q};
	assign den_w  = {1'b0, p_q} + {1'b0, r_noise_q};

	assign div_start   = (state_q == ST_START);
	assign mul_start   = (state_q == ST_DIV) && div_done;
	assign one_minus_g = GAIN_ONE - div_quo;

	skf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (p_q),
		.den    (den_w),
		.done   (div_done),
		.quo    (div_quo)
	);

	// correction term: floor(g * diff / 2^16)
	skf_mul u_mul_est (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.mcand  ({diff_q[DATA_W], diff_q}),
		.mplier (div_quo),
		.done   (mul_e_done),
		.prod   (prod_e)
	);

	// new variance: floor(p * (1 - g) / 2^16)
	skf_mul u_mul_var (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.mcand  ({2'b00, p_q}),
		.mplier (one_minus_g),
		.done   (mul_v_done),
		.prod   (prod_v)
	);

	// corrected estimate lies between old estimate and measurement; clamp as guard
	assign est_sum = {{(ACC_W-DATA_W){est_q[DATA_W-1]}}, est_q} + prod_e;
	always_comb begin
		if (est_sum[ACC_W-1:DATA_W-1] == '0 || est_sum[ACC_W-1:DATA_W-1] == '1) begin
			est_clamped = est_sum[DATA_W-1:0];
		end else if (est_sum[ACC_W-1]) begin
			est_clamped = {1'b1, {(DATA_W-1){1'b0}}};
		end else begin
			est_clamped = {1'b0, {(DATA_W-1){1'b1}}};
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= (in_ch.operation == OP_RESTART) ? ST_DONE : ST_PRED;
					end
				end
				ST_PRED:  state_q <= ST_START;
				ST_START: state_q <= ST_DIV;
				ST_DIV: begin
					if (div_done) state_q <= ST_MUL;
				end
				ST_MUL: begin
					if (mul_e_done) state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_load) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// item datapath registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			meas_q <= in_ch.measurement;
			if (in_ch.operation == OP_RESTART) begin
				res_est_q <= init_est_q;
				res_var_q <= init_var_q;
				gain_q    <= '0;
			end
		end
		if (state_q == ST_PRED) begin
			p_q    <= p_sum[DATA_W] ? '1 : p_sum[DATA_W-1:0];
			diff_q <= diff_w;
		end
		if (mul_start) begin
			gain_q <= div_quo;
		end
		if ((state_q == ST_MUL) && mul_e_done) begin
			res_est_q <= est_clamped;
			res_var_q <= prod_v[DATA_W-1:0];
		end
	end

	// filter state commits together with the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			est_q <= '0;
			var_q <= FIX_ONE;
		end else if (out_load) begin
			est_q <= res_est_q;
			var_q <= res_var_q;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_est_q  <= res_est_q;
			out_gain_q <= gain_q;
			out_var_q  <= res_var_q;
		end
	end

	assign out_ch.valid          = out_valid_q;
	assign out_ch.filtered_value = out_est_q;
	assign out_ch.kalman_gain    = out_gain_q;
	assign out_ch.error_variance = out_var_q;

	a_div_done_expected: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV)
		else $error("divider finished outside its wait state");

	a_mul_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		mul_e_done == mul_v_done)
		else $error("multipliers out of step");

	a_gain_range: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> div_quo <= GAIN_ONE)
		else $error("gain above 1.0");

	a_var_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL) && mul_v_done |-> $unsigned(prod_v) <= ACC_W'(p_q))
		else $error("updated variance above predicted variance");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_DONE)
		else $error("result loaded outside the final state");

endmodule
